### hdl/fpdc_pkg.sv
// Shared types, constants and the flow-to-duty conversion for the flow PID duty controller.
// No dependencies; imported by every module of the block.
package fpdc_pkg;

  localparam int unsigned DriveMaxDef  = 255;
  localparam int unsigned FlowLimitDef = 115;

  localparam int unsigned FlowW  = 10;  // widest flow value (target flow port)
  localparam int unsigned MFlowW = 8;   // measured flow port
  localparam int unsigned DutyW  = 10;  // duty of any flow up to 1023
  localparam int unsigned MDutyW = 9;   // duty of a measured flow, 0..268
  localparam int unsigned GainW  = 16;

  // Reciprocal of 163 scaled by 2^32, rounded up. Exact for numerators below ~418000.
  localparam logic [24:0] DutyRecip  = 25'd26349493;
  localparam logic [16:0] DutyScale  = 17'd100;
  localparam logic [16:0] DutyOffset = 17'd18200;

  localparam logic signed [GainW-1:0] PropGainRst  = 16'sd60;
  localparam logic signed [GainW-1:0] IntegGainRst = 16'sd0;
  localparam logic signed [GainW-1:0] DerivGainRst = 16'sd13;
  localparam logic signed [GainW-1:0] IntegUpRst   = 16'sd10;
  localparam logic signed [GainW-1:0] IntegLoRst   = -16'sd10;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_UPPER = 3'd3,
    REG_INTEG_LOWER = 3'd4
  } fpdc_reg_e;

  typedef struct packed {
    logic signed [GainW-1:0] prop_gain;
    logic signed [GainW-1:0] integ_gain;
    logic signed [GainW-1:0] deriv_gain;
    logic signed [GainW-1:0] integ_upper;
    logic signed [GainW-1:0] integ_lower;
  } fpdc_cfg_t;

  // Duty = (flow*100 + 18200) / 163, with a flow of zero giving zero.
  function automatic logic [DutyW-1:0] duty_of(input logic [FlowW-1:0] flow);
    logic [16:0] num;
    logic [41:0] prod;
    num  = {7'b0, flow} * DutyScale + DutyOffset;
    prod = {25'b0, num} * {17'b0, DutyRecip};
    if (flow == '0) begin
      return '0;
    end
    return prod[41:32];
  endfunction

endpackage

### hdl/flow_pid_duty_controller.sv
// Top level of the flow PID duty controller: stream ports, APB register port, two-stage datapath.
// Depends on fpdc_pkg, fpdc_regs, fpdc_in_stage and fpdc_pid.
//
//   channel     | direction | payload
//   ------------+-----------+--------------------------------------------------------
//   s_axis      | in        | measured_flow[7:0], target_flow[17:8]
//   m_axis      | out       | drive[7:0], motor_on[8], measured_duty[17:9]
//   apb         | in/out    | five 16-bit signed registers at byte addresses 0..16
//
// Unless the output stalls, one item is accepted per cycle; both stages register it.
// The first stage saturates the target flow and converts both flows to duty units.
// The second stage runs the PID step and the clamps and holds the controller state,
// which doubles as the result register, so the feedback loop closes within the second stage.
// Reset clears the controller state and loads the register defaults.
// A stalled result holds in place while the input stage can still take one more item.
module flow_pid_duty_controller import fpdc_pkg::*; #(
  parameter int unsigned DRIVE_MAX  = DriveMaxDef,
  parameter int unsigned FLOW_LIMIT = FlowLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] measured_flow, [17:8] target_flow, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] drive, [8] motor_on, [17:9] measured_duty, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fpdc_cfg_t         cfg;
  logic              mid_valid;
  logic              mid_ready;
  logic [MDutyW-1:0] mid_mduty;
  logic [DutyW-1:0]  mid_tduty;
  logic [7:0]        drive;
  logic              motor_on;
  logic [MDutyW-1:0] measured_duty;

  fpdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Flow conversion and input register.
  fpdc_in_stage #(
    .FLOW_LIMIT (FLOW_LIMIT)
  ) u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .measured_flow_i (s_axis_tdata[7:0]),
    .target_flow_i   (s_axis_tdata[17:8]),
    .out_valid_o     (mid_valid),
    .out_ready_i     (mid_ready),
    .mduty_o         (mid_mduty),
    .tduty_o         (mid_tduty)
  );

  // PID step; its state registers present the result.
  fpdc_pid #(
    .DRIVE_MAX (DRIVE_MAX)
  ) u_pid (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (mid_valid),
    .in_ready_o      (mid_ready),
    .mduty_i         (mid_mduty),
    .tduty_i         (mid_tduty),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .drive_o         (drive),
    .motor_on_o      (motor_on),
    .measured_duty_o (measured_duty)
  );

  assign m_axis_tdata = {6'b0, measured_duty, motor_on, drive};

endmodule

### hdl/fpdc_regs.sv
// Configuration register file with an APB-style port for the flow PID duty controller.
// Depends on fpdc_pkg for register codes, reset values and the config struct.
module fpdc_regs import fpdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output fpdc_cfg_t   cfg_o
);

  fpdc_cfg_t cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:   cfg_d.prop_gain   = pwdata[15:0];
        REG_INTEG_GAIN:  cfg_d.integ_gain  = pwdata[15:0];
        REG_DERIV_GAIN:  cfg_d.deriv_gain  = pwdata[15:0];
        REG_INTEG_UPPER: cfg_d.integ_upper = pwdata[15:0];
        REG_INTEG_LOWER: cfg_d.integ_lower = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROP_GAIN:   prdata = 32'(cfg_q.prop_gain);
      REG_INTEG_GAIN:  prdata = 32'(cfg_q.integ_gain);
      REG_DERIV_GAIN:  prdata = 32'(cfg_q.deriv_gain);
      REG_INTEG_UPPER: prdata = 32'(cfg_q.integ_upper);
      REG_INTEG_LOWER: prdata = 32'(cfg_q.integ_lower);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PropGainRst;
      cfg_q.integ_gain  <= IntegGainRst;
      cfg_q.deriv_gain  <= DerivGainRst;
      cfg_q.integ_upper <= IntegUpRst;
      cfg_q.integ_lower <= IntegLoRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hdl/fpdc_in_stage.sv
// Input stage: saturates the target flow, converts both flows to duty units and registers them.
// Depends on fpdc_pkg for the conversion function and widths.
module fpdc_in_stage import fpdc_pkg::*; #(
  parameter int unsigned FLOW_LIMIT = FlowLimitDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MFlowW-1:0] measured_flow_i,
  input  logic [FlowW-1:0]  target_flow_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MDutyW-1:0] mduty_o,
  output logic [DutyW-1:0]  tduty_o
);

  localparam logic [FlowW-1:0] FlowLim = FlowW'(FLOW_LIMIT);

  logic              valid_q, valid_d;
  logic [MDutyW-1:0] mduty_q;
  logic [DutyW-1:0]  tduty_q;
  logic [FlowW-1:0]  tflow_sat;
  logic [DutyW-1:0]  mduty_full;
  logic              load;

  assign tflow_sat  = (target_flow_i > FlowLim) ? FlowLim : target_flow_i;
  assign mduty_full = duty_of({2'b0, measured_flow_i});

  assign in_ready_o = ~valid_q | out_ready_i;
  assign load       = in_valid_i & in_ready_o;
  assign valid_d    = load | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mduty_q <= mduty_full[MDutyW-1:0];
      tduty_q <= duty_of(tflow_sat);
    end
  end

  assign out_valid_o = valid_q;
  assign mduty_o     = mduty_q;
  assign tduty_o     = tduty_q;

endmodule

### hdl/fpdc_pid.sv
// PID step with integrator clamp and drive clamp; its state registers also form the result register.
// Depends on fpdc_pkg for widths and the config struct.
module fpdc_pid import fpdc_pkg::*; #(
  parameter int unsigned DRIVE_MAX = DriveMaxDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpdc_cfg_t         cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MDutyW-1:0] mduty_i,
  input  logic [DutyW-1:0]  tduty_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        drive_o,
  output logic              motor_on_o,
  output logic [MDutyW-1:0] measured_duty_o
);

  localparam int unsigned DaccW = $clog2(DRIVE_MAX + 1);
  localparam int unsigned SumW  = ((DaccW + 1) > 25 ? (DaccW + 1) : 25) + 2;
  localparam logic signed [SumW-1:0] DriveMaxS = SumW'(DRIVE_MAX);
  localparam logic [DaccW-1:0]       DriveMaxU = DaccW'(DRIVE_MAX);

  logic                     out_valid_q;
  logic signed [GainW-1:0]  integ_acc_q, integ_acc_d;
  logic [MDutyW-1:0]        prev_duty_q;
  logic [DaccW-1:0]         drive_acc_q, drive_acc_d;
  logic                     adv;

  logic signed [10:0]       err;
  logic signed [26:0]       pprod;
  logic signed [19:0]       pterm;
  logic signed [16:0]       iacc_sum;
  logic signed [31:0]       iprod;
  logic signed [24:0]       iterm;
  logic signed [9:0]        ddiff;
  logic signed [25:0]       dprod;
  logic signed [18:0]       dterm;
  logic signed [SumW-1:0]   sum;
  logic [DaccW+7:0]         drive_ext;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign adv        = in_valid_i & in_ready_o;

  assign err   = $signed({1'b0, tduty_i}) - $signed({2'b0, mduty_i});
  assign pprod = cfg_i.prop_gain * err;
  assign pterm = 20'(pprod >>> 7);

  // Integrator: upper bound tested first; with crossed bounds only sums above it settle on it.
  assign iacc_sum = 17'(integ_acc_q) + 17'(err);
  always_comb begin
    if (iacc_sum > 17'(cfg_i.integ_upper)) begin
      integ_acc_d = cfg_i.integ_upper;
    end else if (iacc_sum < 17'(cfg_i.integ_lower)) begin
      integ_acc_d = cfg_i.integ_lower;
    end else begin
      integ_acc_d = iacc_sum[15:0];
    end
  end
  assign iprod = cfg_i.integ_gain * integ_acc_d;
  assign iterm = 25'(iprod >>> 7);

  assign ddiff = $signed({1'b0, prev_duty_q}) - $signed({1'b0, mduty_i});
  assign dprod = cfg_i.deriv_gain * ddiff;
  assign dterm = 19'(dprod >>> 7);

  assign sum = SumW'(pterm) + SumW'(iterm) + SumW'(dterm) + $signed(SumW'({1'b0, drive_acc_q}));

  always_comb begin
    if (tduty_i == '0) begin
      drive_acc_d = '0;
    end else if (sum > DriveMaxS) begin
      drive_acc_d = DriveMaxU;
    end else if (sum < 0) begin
      drive_acc_d = '0;
    end else begin
      drive_acc_d = sum[DaccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_acc_q <= '0;
      prev_duty_q <= '0;
      drive_acc_q <= '0;
    end else begin
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
      if (adv) begin
        integ_acc_q <= integ_acc_d;
        prev_duty_q <= mduty_i;
        drive_acc_q <= drive_acc_d;
      end
    end
  end

  assign drive_ext       = {8'b0, drive_acc_q};
  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_ext[7:0];
  assign motor_on_o      = (drive_acc_q != '0);
  assign measured_duty_o = prev_duty_q;

  a_drive_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_acc_q <= DriveMaxU)
    else $error("accumulated drive exceeds its maximum");

  a_target_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && tduty_i == '0) |=> (drive_acc_q == '0))
    else $error("drive not forced to zero for a zero target");

  a_prev_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (prev_duty_q == $past(mduty_i) && out_valid_q))
    else $error("measured duty not captured with the item");

endmodule
